>>> hdl/ddo_pkg.sv
// shared types, constants and tables for the wheel odometry unit
package ddo_pkg;

    localparam int COUNT_W   = 32;
    localparam int POS_W     = 44;
    localparam int ANGLE_W   = 16;
    localparam int LIN_W     = 24;
    localparam int CFG_W     = 24;
    localparam int DIST_W    = 38;
    localparam int MCAND_W   = 40;
    localparam int PROD_W    = 64;
    localparam int MUL_STEPS = 24;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W    = $clog2(CORDIC_STEPS);
    localparam int CORD_W    = 34;
    localparam logic signed [CORD_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

    localparam logic [1:0] REG_MM_PER_COUNT = 2'd0;
    localparam logic [1:0] REG_TURN_GAIN    = 2'd1;
    localparam logic [1:0] REG_STRAIGHT_TOL = 2'd2;
    localparam logic [1:0] REG_INVERT_LEFT  = 2'd3;

    localparam logic [1:0] KIND_STRAIGHT = 2'd0;
    localparam logic [1:0] KIND_ROTATE   = 2'd1;
    localparam logic [1:0] KIND_ARC      = 2'd2;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } t_odo_in;

    typedef struct packed {
        logic signed [43:0] pos_x;
        logic signed [43:0] pos_y;
        logic [15:0]        heading;
        logic signed [23:0] linear_step;
        logic signed [15:0] angular_step;
        logic [1:0]         motion_kind;
    } t_odo_out;

    // atan(2^-i) as a fraction of a turn, scaled by 2^32
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/diff_drive_wheel_odometry_unit.sv
// top level of the differential drive wheel odometry unit
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_in_data   (t_odo_in)
//  output    out        o_out_valid / i_out_ready  o_out_data  (t_odo_out)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one transaction at a time; a move runs two passes of the serial multipliers (wheel
// distance, then turn), then the cordic and one more multiplier pass for the position
// increment, with sequencing states between them; a pure rotation ends after the
// two multiplier passes
// reset (i_rst_n low at a clock edge) clears pose and previous counts, sets config defaults
// a result waits in the output register until taken; the next transaction can be taken
// in the cycle after the previous result has been loaded there
module diff_drive_wheel_odometry_unit
    import ddo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_odo_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_odo_out         o_out_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL_D  = 7'b0000010,
        S_PREP   = 7'b0000100,
        S_MUL_T  = 7'b0001000,
        S_CORDIC = 7'b0010000,
        S_MUL_P  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [23:0] r_mpc, r_gain;
    logic [9:0]  r_tol;
    logic        r_inv;

    // pose and history
    logic [COUNT_W-1:0] r_prev_l, r_prev_r;
    logic [POS_W-1:0]   r_x, r_y;
    logic [ANGLE_W-1:0] r_head;

    // per-transaction working values
    logic                     r_l_pos, r_l_neg, r_r_pos, r_r_neg;
    logic signed [DIST_W-1:0] r_dl, r_dr;
    logic signed [LIN_W-1:0]  r_lin;
    logic [1:0]               r_kind;
    logic [ANGLE_W-1:0]       r_turn;

    t_odo_out r_out;
    logic     r_out_valid;
    logic     out_load;

    // serial units
    logic                      mul_start;
    logic signed [MCAND_W-1:0] mc0, mc1;
    logic [MUL_STEPS-1:0]      mp;
    logic                      mp_signed;
    logic signed [PROD_W-1:0]  p0, p1;
    logic                      mul_done, mul_done_unused;
    logic                      cor_start, cor_done;
    logic [ANGLE_W-1:0]        cor_angle;
    logic signed [CORD_W-1:0]  cor_c, cor_s;

    logic                     in_fire;
    logic [COUNT_W-1:0]       l_eff, dlc, drc;
    logic [PROD_W-1:0]        rnd0, rnd1, rndt, rpx, rpy;
    logic signed [DIST_W:0]   wd, wd_abs, sum_d;
    logic signed [DIST_W-1:0] half;
    logic                     near;
    logic [1:0]               kind;
    logic [ANGLE_W-1:0]       turn_new;
    logic [POS_W-1:0]         dx, dy;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // result moves into the output register once that register is free or being taken
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // count differences wrap at the counter width
    assign l_eff = r_inv ? (COUNT_W'(0) - i_in_data.left_count) : i_in_data.left_count;
    assign dlc   = l_eff - r_prev_l;
    assign drc   = i_in_data.right_count - r_prev_r;

    // round half up, then take the scaled wheel steps
    assign rnd0 = p0 + PROD_W'(64'd524288);
    assign rnd1 = p1 + PROD_W'(64'd524288);
    assign rndt = rnd0;

    assign wd     = (DIST_W+1)'(r_dr) - (DIST_W+1)'(r_dl);
    assign wd_abs = wd[DIST_W] ? -wd : wd;
    assign sum_d  = (DIST_W+1)'(r_dl) + (DIST_W+1)'(r_dr);
    assign half   = sum_d[DIST_W:1];
    assign near   = (wd_abs <= (DIST_W+1)'({r_tol, 4'b0000}));

    always_comb begin
        if (near && ((r_l_pos && r_r_pos) || (r_l_neg && r_r_neg))) begin
            kind = KIND_STRAIGHT;
        end else if (near && ((r_l_pos && r_r_neg) || (r_l_neg && r_r_pos))) begin
            kind = KIND_ROTATE;
        end else begin
            kind = KIND_ARC;
        end
    end

    assign turn_new = rndt[20 +: ANGLE_W];

    // straight moves along the heading, arcs along the heading plus half the turn
    assign cor_angle = (r_kind == KIND_STRAIGHT) ? r_head
                     : r_head + {turn_new[ANGLE_W-1], turn_new[ANGLE_W-1:1]};
    assign cor_start = (r_state == S_MUL_T) && mul_done && (r_kind != KIND_ROTATE);

    assign rpx = p0 + PROD_W'(64'd536870912);
    assign rpy = p1 + PROD_W'(64'd536870912);
    assign dx  = POS_W'($signed(rpx[PROD_W-1:30]));
    assign dy  = POS_W'($signed(rpy[PROD_W-1:30]));

    // operand selection for the two shared multipliers
    always_comb begin
        mul_start = 1'b0;
        mc0       = MCAND_W'($signed(dlc));
        mc1       = MCAND_W'($signed(drc));
        mp        = r_mpc;
        mp_signed = 1'b0;
        if (in_fire) begin
            mul_start = 1'b1;
        end else if (r_state == S_PREP) begin
            mul_start = 1'b1;
            mc0       = MCAND_W'(wd);
            mc1       = '0;
            mp        = r_gain;
        end else if ((r_state == S_CORDIC) && cor_done) begin
            mul_start = 1'b1;
            mc0       = MCAND_W'(cor_c);
            mc1       = MCAND_W'(cor_s);
            mp        = r_lin;
            mp_signed = 1'b1;
        end
    end

    ddo_mul u_mul0 (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (mul_start),
        .i_mcand         (mc0),
        .i_mplier        (mp),
        .i_mplier_signed (mp_signed),
        .o_product       (p0),
        .o_done          (mul_done)
    );

    ddo_mul u_mul1 (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (mul_start),
        .i_mcand         (mc1),
        .i_mplier        (mp),
        .i_mplier_signed (mp_signed),
        .o_product       (p1),
        .o_done          (mul_done_unused)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_cos   (cor_c),
        .o_sin   (cor_s),
        .o_done  (cor_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mpc       <= 24'd26133;
            r_gain      <= 24'd1627529;
            r_tol       <= 10'd20;
            r_inv       <= 1'b1;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MM_PER_COUNT: r_mpc  <= i_cfg_data;
                    REG_TURN_GAIN:    r_gain <= i_cfg_data;
                    REG_STRAIGHT_TOL: r_tol  <= i_cfg_data[9:0];
                    REG_INVERT_LEFT:  r_inv  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_prev_l <= l_eff;
                        r_prev_r <= i_in_data.right_count;
                        r_state  <= S_MUL_D;
                    end
                end
                S_MUL_D: begin
                    if (mul_done) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_MUL_T;
                end
                S_MUL_T: begin
                    if (mul_done) begin
                        if (r_kind == KIND_ROTATE) begin
                            r_head  <= r_head + turn_new;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC: begin
                    if (cor_done) begin
                        r_state <= S_MUL_P;
                    end
                end
                S_MUL_P: begin
                    if (mul_done) begin
                        r_x <= r_x + dx;
                        r_y <= r_y + dy;
                        if (r_kind == KIND_ARC) begin
                            r_head <= r_head + r_turn;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the result back while the previous one is still waiting
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end

        // working values, no reset needed
        if (in_fire) begin
            r_l_pos <= !dlc[COUNT_W-1] && (dlc != '0);
            r_l_neg <= dlc[COUNT_W-1];
            r_r_pos <= !drc[COUNT_W-1] && (drc != '0);
            r_r_neg <= drc[COUNT_W-1];
        end
        if ((r_state == S_MUL_D) && mul_done) begin
            r_dl <= rnd0[20 +: DIST_W];
            r_dr <= rnd1[20 +: DIST_W];
        end
        if (r_state == S_PREP) begin
            r_kind <= kind;
            if (half > DIST_W'(24'sd8388607)) begin
                r_lin <= 24'sd8388607;
            end else if (half < -DIST_W'(25'sd8388608)) begin
                r_lin <= -24'sd8388608;
            end else begin
                r_lin <= half[LIN_W-1:0];
            end
        end
        if ((r_state == S_MUL_T) && mul_done) begin
            r_turn <= turn_new;
        end
        if (out_load) begin
            r_out.pos_x        <= r_x;
            r_out.pos_y        <= r_y;
            r_out.heading      <= r_head;
            r_out.linear_step  <= r_lin;
            r_out.angular_step <= (r_kind == KIND_STRAIGHT) ? '0 : r_turn;
            r_out.motion_kind  <= r_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/ddo_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module ddo_mul
    import ddo_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [MCAND_W-1:0] i_mcand,
    input  logic [MUL_STEPS-1:0]      i_mplier,
    input  logic                      i_mplier_signed,
    output logic signed [PROD_W-1:0]  o_product,
    output logic                      o_done
);

    logic [PROD_W-1:0]    r_mcand, n_mcand;
    logic [MUL_STEPS-1:0] r_mplier, n_mplier;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic                 r_sgn, n_sgn;
    logic                 last;

    assign last = (r_cnt == MUL_CNT_W'(MUL_STEPS - 1));

    always_comb begin
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_prod   = r_prod;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_sgn    = r_sgn;
        n_done   = 1'b0;
        if (i_start) begin
            n_mcand  = PROD_W'(i_mcand);
            n_mplier = i_mplier;
            n_prod   = '0;
            n_cnt    = '0;
            n_busy   = 1'b1;
            n_sgn    = i_mplier_signed;
        end else if (r_busy) begin
            // top bit of a signed multiplier carries negative weight
            if (r_mplier[0]) begin
                if (last && r_sgn) begin
                    n_prod = r_prod - r_mcand;
                end else begin
                    n_prod = r_prod + r_mcand;
                end
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 1'b1;
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_prod   <= n_prod;
        r_sgn    <= n_sgn;
    end

    assign o_product = r_prod;
    assign o_done    = r_done;

endmodule

>>> hdl/ddo_cordic.sv
// iterative rotation cordic, one micro-rotation per cycle
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ANGLE_W-1:0]       i_angle,
    output logic signed [CORD_W-1:0] o_cos,
    output logic signed [CORD_W-1:0] o_sin,
    output logic                     o_done
);

    logic signed [CORD_W-1:0] r_x, n_x;
    logic signed [CORD_W-1:0] r_y, n_y;
    logic signed [CORD_W-1:0] r_z, n_z;
    logic [ITER_W-1:0]        r_iter, n_iter;
    logic                     r_flip, n_flip;
    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [31:0]              z_full;
    logic                     flip_in;
    logic signed [CORD_W-1:0] xs, ys, at;

    assign z_full  = {i_angle, (32 - ANGLE_W)'(0)};
    assign flip_in = z_full[31] ^ z_full[30];
    assign xs = r_x >>> r_iter;
    assign ys = r_y >>> r_iter;
    assign at = CORD_W'(atan_entry(5'(r_iter)));

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_iter = r_iter;
        n_flip = r_flip;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // fold second and third quadrant onto the right half plane
            n_flip = flip_in;
            n_z    = CORD_W'($signed({z_full[31] ^ flip_in, z_full[30:0]}));
            n_x    = CORDIC_INV_GAIN;
            n_y    = '0;
            n_iter = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_z[CORD_W-1]) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - at;
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + at;
            end
            n_iter = r_iter + 1'b1;
            if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_flip <= n_flip;
    end

    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
    assign o_done = r_done;

endmodule
